// File: src/asrb_pkg.sv
// Shared types and constants of the auto-ranging sample ring buffer.
package asrb_pkg;

  localparam int RING_DEPTH = 256;
  localparam int MAX_BURST  = 32;

  localparam int PTR_W     = $clog2(RING_DEPTH);
  localparam int CNT_W     = $clog2(RING_DEPTH + 1);
  localparam int BURST_W   = $clog2(MAX_BURST + 1);
  localparam int MAXE_W    = 6;
  localparam int VALUE_W   = 16;
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  localparam logic [CFG_W-1:0] HR_LOW_LIMIT_RST  = 16'd15;
  localparam logic [CFG_W-1:0] LR_HIGH_LIMIT_RST = 16'd3972;

  localparam logic [CFG_IDX_W-1:0] REG_HR_LOW_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LR_HIGH_LIMIT = 1'd1;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [VALUE_W-1:0] sample_value;
    logic [TIME_W-1:0]  sample_time;
    logic [MAXE_W-1:0]  max_entries;
  } in_req_t;

  typedef struct packed {
    logic               hi_range;
    logic               stored;
    logic               entry_valid;
    logic [TIME_W-1:0]  entry_time;
    logic [VALUE_W-1:0] entry_value;
    logic [CNT_W-1:0]   fill_count;
    logic               last;
  } out_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic item_rsp;
    logic burst_start;
    logic mem_rd;
    logic entry_rsp;
    logic last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [BURST_W-1:0] burst_len;
  } sts_t;

endpackage

// File: src/asrb_if.sv
// Request and response channel interfaces of the auto-ranging sample ring buffer.
interface asrb_in_if;
  import asrb_pkg::*;
  logic    valid;
  logic    ready;
  in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface asrb_out_if;
  import asrb_pkg::*;
  logic     valid;
  logic     ready;
  out_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/autorange_sample_ring_buffer.sv
// Top level of the auto-ranging sample ring buffer.
// A sample, clear or unused-op request gives one response;
// the next request is accepted in the following cycle as long as the response
// register is taken. A read request for n entries (n = the smallest of
// max_entries, 32 and the fill count) is accepted and starts the burst, then
// makes the first memory read, then returns one entry per cycle while the
// response register is taken, paced by the registered read of the single-port
// 256-entry sample memory. An empty read gives one response with entry_valid
// low. No requests are accepted during a burst. The memory needs no clearing
// after reset; only written entries are ever returned.
module autorange_sample_ring_buffer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  asrb_in_if.sink                         in_i,
  asrb_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [asrb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [asrb_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import asrb_pkg::*;

  cmd_t     cmd;
  sts_t     sts;
  out_rsp_t out_data;
  logic     in_ready;
  logic     out_valid;

  asrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.data.op),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  asrb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

  // A request is only taken when the response register is free this cycle.
  a_accept_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (!out_o.valid || out_o.ready))
    else $error("request accepted while response register blocked");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.fill_count <= CNT_W'(RING_DEPTH)))
    else $error("fill count above ring depth");

  // Between entries of one burst no new request may enter.
  a_burst_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.entry_valid && !out_o.data.last) |-> !in_i.ready)
    else $error("request taken in the middle of a read burst");

  // A response that is not the last one always carries an entry.
  a_nonlast_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.last) |-> out_o.data.entry_valid)
    else $error("non-final response without an entry");

endmodule

// File: src/asrb_ctrl.sv
// Controller state machine: request handshake, read bursts and output valid.
module asrb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  asrb_pkg::op_e   in_op_i,
  input  logic            out_ready_i,
  input  asrb_pkg::sts_t  sts_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output asrb_pkg::cmd_t  cmd_o
);
  import asrb_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_BURST = 1'b1;

  logic               state_q, state_d;
  logic [BURST_W-1:0] issue_left_q, issue_left_d;
  logic [BURST_W-1:0] deliver_left_q, deliver_left_d;
  logic               rdv_q, rdv_d;
  logic               out_valid_q, out_valid_d;

  logic slot_free;
  logic accept;
  logic is_burst;
  logic deliver;
  logic issue;

  assign slot_free = !out_valid_q || out_ready_i;
  assign is_burst  = (in_op_i == OP_READ) && (sts_i.burst_len != '0);

  always_comb begin
    state_d        = state_q;
    issue_left_d   = issue_left_q;
    deliver_left_d = deliver_left_q;
    rdv_d          = rdv_q;
    in_ready_o     = 1'b0;
    accept         = 1'b0;
    deliver        = 1'b0;
    issue          = 1'b0;
    cmd_o          = '0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = slot_free;
        accept     = in_valid_i && slot_free;
        if (accept) begin
          if (is_burst) begin
            cmd_o.burst_start = 1'b1;
            issue_left_d      = sts_i.burst_len;
            deliver_left_d    = sts_i.burst_len;
            rdv_d             = 1'b0;
            state_d           = ST_BURST;
          end else begin
            cmd_o.item_rsp = 1'b1;
          end
        end
      end
      ST_BURST: begin
        // The read data register holds one entry; a new read is issued only
        // when that register is empty or is being emptied in this cycle.
        deliver = rdv_q && slot_free;
        issue   = (issue_left_q != '0) && (!rdv_q || deliver);
        cmd_o.entry_rsp = deliver;
        cmd_o.mem_rd    = issue;
        cmd_o.last      = (deliver_left_q == BURST_W'(1));
        if (issue) begin
          issue_left_d = issue_left_q - 1'b1;
          rdv_d        = 1'b1;
        end else if (deliver) begin
          rdv_d = 1'b0;
        end
        if (deliver) begin
          deliver_left_d = deliver_left_q - 1'b1;
          if (deliver_left_q == BURST_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cmd_o.item_rsp || cmd_o.entry_rsp) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      issue_left_q   <= '0;
      deliver_left_q <= '0;
      rdv_q          <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      issue_left_q   <= issue_left_d;
      deliver_left_q <= deliver_left_d;
      rdv_q          <= rdv_d;
      out_valid_q    <= out_valid_d;
    end
  end

endmodule

// File: src/asrb_dp.sv
// Datapath: range limits, range flag, ring pointers, sample memory and output register.
module asrb_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  asrb_pkg::in_req_t                    in_data_i,
  input  logic                                 cfg_we_i,
  input  logic [asrb_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [asrb_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  asrb_pkg::cmd_t                       cmd_i,
  output asrb_pkg::sts_t                       sts_o,
  output asrb_pkg::out_rsp_t                   out_data_o
);
  import asrb_pkg::*;

  localparam int CmpA = (CNT_W > BURST_W) ? CNT_W : BURST_W;
  localparam int CmpW = (CmpA > MAXE_W) ? CmpA : MAXE_W;
  localparam int EntW = TIME_W + VALUE_W;

  logic [CFG_W-1:0]   hr_low_limit_q;
  logic [CFG_W-1:0]   lr_high_limit_q;
  logic               range_q, range_d;
  logic [PTR_W-1:0]   wp_q;
  logic [CNT_W-1:0]   held_q;
  logic [PTR_W-1:0]   rd_idx_q;
  logic [EntW-1:0]    mem_q [RING_DEPTH];
  logic [EntW-1:0]    rdata_q;
  out_rsp_t           out_q, out_d;

  logic               keep;
  logic               mem_we;
  logic [CNT_W-1:0]   held_inc;
  logic [CNT_W-1:0]   held_dec;
  logic [PTR_W-1:0]   wp_inc;
  logic [PTR_W-1:0]   rd_inc;
  logic [CNT_W:0]     start_sum;
  logic [CNT_W:0]     start_wrap;
  logic [PTR_W-1:0]   rd_start;
  logic [CmpW-1:0]    req_n, n_cap, n_held;

  // Range switch decision for a sample request.
  always_comb begin
    range_d = range_q;
    keep    = 1'b1;
    if (range_q) begin
      if (in_data_i.sample_value < hr_low_limit_q) begin
        range_d = 1'b0;
      end
    end else if (in_data_i.sample_value > lr_high_limit_q) begin
      range_d = 1'b1;
      keep    = 1'b0;
    end
  end

  assign mem_we   = cmd_i.item_rsp && (in_data_i.op == OP_SAMPLE) && keep;
  assign held_inc = (held_q == CNT_W'(RING_DEPTH)) ? held_q : held_q + 1'b1;
  assign held_dec = held_q - 1'b1;
  assign wp_inc   = (wp_q == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rd_inc   = (rd_idx_q == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;

  // Oldest entry sits held_q places behind the write pointer, modulo the depth.
  assign start_sum  = (CNT_W + 1)'(wp_q) + (CNT_W + 1)'(RING_DEPTH) - (CNT_W + 1)'(held_q);
  assign start_wrap = (start_sum >= (CNT_W + 1)'(RING_DEPTH)) ?
                      start_sum - (CNT_W + 1)'(RING_DEPTH) : start_sum;
  assign rd_start   = start_wrap[PTR_W-1:0];

  always_comb begin
    req_n  = CmpW'(in_data_i.max_entries);
    n_cap  = (req_n > CmpW'(MAX_BURST)) ? CmpW'(MAX_BURST) : req_n;
    n_held = (n_cap > CmpW'(held_q)) ? CmpW'(held_q) : n_cap;
  end

  assign sts_o.burst_len = n_held[BURST_W-1:0];

  always_comb begin
    out_d             = '0;
    out_d.hi_range    = range_q;
    out_d.fill_count  = held_q;
    out_d.last        = 1'b1;
    if (cmd_i.entry_rsp) begin
      out_d.entry_valid = 1'b1;
      out_d.entry_time  = rdata_q[EntW-1:VALUE_W];
      out_d.entry_value = rdata_q[VALUE_W-1:0];
      out_d.fill_count  = held_dec;
      out_d.last        = cmd_i.last;
    end else begin
      case (in_data_i.op)
        OP_SAMPLE: begin
          out_d.hi_range   = range_d;
          out_d.stored     = keep;
          out_d.fill_count = keep ? held_inc : held_q;
        end
        OP_CLEAR: begin
          out_d.fill_count = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hr_low_limit_q  <= HR_LOW_LIMIT_RST;
      lr_high_limit_q <= LR_HIGH_LIMIT_RST;
      range_q         <= 1'b0;
      wp_q            <= '0;
      held_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_HR_LOW_LIMIT:  hr_low_limit_q  <= cfg_wdata_i;
          REG_LR_HIGH_LIMIT: lr_high_limit_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.item_rsp) begin
        case (in_data_i.op)
          OP_SAMPLE: begin
            range_q <= range_d;
            if (keep) begin
              wp_q   <= wp_inc;
              held_q <= held_inc;
            end
          end
          OP_CLEAR: begin
            wp_q   <= '0;
            held_q <= '0;
          end
          default: begin
          end
        endcase
      end else if (cmd_i.entry_rsp) begin
        held_q <= held_dec;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.burst_start) begin
      rd_idx_q <= rd_start;
    end else if (cmd_i.mem_rd) begin
      rd_idx_q <= rd_inc;
    end
    if (cmd_i.item_rsp || cmd_i.entry_rsp) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= {in_data_i.sample_time, in_data_i.sample_value};
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[rd_idx_q];
    end
  end

  assign out_data_o = out_q;

endmodule
